FILE: design/tpls_pkg.sv
// ----------------------------------------------------------------------------
// tpls_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tpls_pkg;

	localparam int FRAC_BITS = 16;
	localparam logic [15:0] EXP_SQUARE = 16'd8192;

	localparam logic [1:0] CFG_NOISE = 2'd0;
	localparam logic [1:0] CFG_EXP   = 2'd1;
	localparam logic [1:0] CFG_COUNT = 2'd2;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	localparam logic [2:0] NORM_LAST = 3'd4;
	localparam logic [4:0] DIV_LAST  = 5'd31;

	typedef struct packed {
		logic capture;
		logic start;
		logic rd;
		logic chk;
		logic next;
		logic norm_step;
		logic log_mul;
		logic exp_calc;
		logic mul_sq;
		logic sq_pow;
		logic mul_mag;
		logic dchk;
		logic div_step;
		logic acc;
		logic out_wr;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic done;
		logic active;
		logic square;
		logic norm_last;
		logic div_need;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

FILE: design/tpls_dp.sv
// ----------------------------------------------------------------------------
// tpls_dp
// Datapath: registers, barrier table, power unit, multiplier, divider, sum.
// ----------------------------------------------------------------------------
module tpls_dp #(
	parameter int MAX_BARRIERS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tpls_pkg::cmd_t      cmd,
	output tpls_pkg::sts_t      sts,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_wdata,
	input  logic                mode,
	input  logic [3:0]          entry_index,
	input  logic signed [31:0]  entry_height,
	input  logic signed [31:0]  entry_amplitude,
	input  logic signed [31:0]  bias,
	input  logic signed [31:0]  measured_current,
	input  logic                last_sample,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic [31:0]         model_current,
	output logic [31:0]         residual,
	output logic                zero_bias,
	output logic                saturated,
	output logic                last_out
);

	localparam int IDX_W = (MAX_BARRIERS > 1) ? $clog2(MAX_BARRIERS) : 1;
	localparam int CNT_W = $clog2(MAX_BARRIERS + 1);
	localparam int ACC_W = 33 + CNT_W;
	localparam int FRAC_BITS = tpls_pkg::FRAC_BITS;

	logic signed [31:0] noise_q;
	logic [15:0]        exp_q;
	logic [4:0]         cnt_q;

	logic [63:0] mem [MAX_BARRIERS];
	logic [63:0] rd_q;

	logic               mode_q, last_q;
	logic signed [31:0] bias_q, meas_q;
	logic [CNT_W-1:0]   j_q;
	logic [CNT_W-1:0]   cnt_eff;

	logic [31:0] d_q, x_q, p_q, quo_q, rem_q;
	logic [4:0]  m_q, dcnt_q;
	logic [2:0]  nstep_q;
	logic signed [39:0] e_q;
	logic [63:0] prod_q;
	logic        bz_q, big_q, zb_q, sat_q;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [31:0] rh, ra;
	logic [31:0]        babs, aabs;
	logic [32:0]        diff;
	logic [4:0]         sh;
	logic               sh_ok;
	logic signed [6:0]  lg_int;
	logic signed [22:0] lg;
	logic signed [12:0] s_e;
	logic [16:0]        mant;
	logic [31:0]        p_gen;
	logic               p_gen_sat;
	logic [32:0]        rem2;
	logic               ge;
	logic               a_neg, t_neg, over;
	logic signed [32:0] term;
	logic signed [31:0] model_c;
	logic               model_sat;
	logic signed [32:0] res_w;
	logic signed [31:0] res_c;
	logic               res_sat;

	assign rh   = rd_q[63:32];
	assign ra   = rd_q[31:0];
	assign babs = bias_q[31] ? 32'(-{bias_q[31], bias_q}) : bias_q;
	assign aabs = ra[31] ? 32'(-{ra[31], ra}) : ra;
	assign diff = {rh[31], rh} - {bias_q[31], bias_q};
	assign cnt_eff = (32'(cnt_q) > MAX_BARRIERS) ? CNT_W'(MAX_BARRIERS) : CNT_W'(cnt_q);

	assign sh    = 5'(5'd16 >> nstep_q);
	assign sh_ok = (x_q >> (6'd32 - {1'b0, sh})) == 32'd0;

	assign lg_int = $signed({2'b00, m_q}) - 7'(FRAC_BITS);
	assign lg     = {lg_int[6:0], x_q[30:15]};
	assign s_e    = $signed(e_q[39:28]) + 13'(tpls_pkg::FRAC_BITS - 16);
	assign mant   = {1'b1, e_q[27:12]};

	always_comb begin
		p_gen_sat = 1'b0;
		if (s_e >= 13'sd16) begin
			p_gen     = 32'hFFFF_FFFF;
			p_gen_sat = 1'b1;
		end else if (s_e >= 13'sd0) begin
			p_gen = {15'd0, mant} << s_e[3:0];
		end else if (s_e <= -13'sd17) begin
			p_gen = 32'd0;
		end else begin
			p_gen = {15'd0, mant >> 5'(-s_e)};
		end
	end

	assign rem2 = {rem_q, quo_q[31]};
	assign ge   = rem2 >= {1'b0, babs};

	always_comb begin
		a_neg = ra[31];
		t_neg = (a_neg == bias_q[31]);
		over  = 1'b0;
		if (bz_q) begin
			if (prod_q == 64'd0)
				term = '0;
			else
				term = a_neg ? 33'sh0_7FFF_FFFF : -33'sh1_0000_0000 + 33'sh0_8000_0000;
		end else if (t_neg) begin
			over = big_q || (quo_q > 32'h8000_0000);
			term = over ? -33'sh0_8000_0000 : -$signed({1'b0, quo_q});
		end else begin
			over = big_q || (quo_q > 32'h7FFF_FFFF);
			term = over ? 33'sh0_7FFF_FFFF : $signed({1'b0, quo_q});
		end
	end

	always_comb begin
		model_sat = 1'b0;
		if (acc_q > ACC_W'(33'sh0_7FFF_FFFF)) begin
			model_c   = 32'sh7FFF_FFFF;
			model_sat = 1'b1;
		end else if (acc_q < -ACC_W'(33'sh0_8000_0000)) begin
			model_c   = 32'sh8000_0000;
			model_sat = 1'b1;
		end else begin
			model_c = acc_q[31:0];
		end
		res_w   = {model_c[31], model_c} - {meas_q[31], meas_q};
		res_sat = 1'b0;
		if (res_w > 33'sh0_7FFF_FFFF) begin
			res_c   = 32'sh7FFF_FFFF;
			res_sat = 1'b1;
		end else if (res_w < -33'sh0_8000_0000) begin
			res_c   = 32'sh8000_0000;
			res_sat = 1'b1;
		end else begin
			res_c = res_w[31:0];
		end
	end

	always_comb begin
		sts.mode      = mode;
		sts.done      = j_q >= cnt_eff;
		sts.active    = bias_q < rh;
		sts.square    = exp_q == tpls_pkg::EXP_SQUARE;
		sts.norm_last = nstep_q == tpls_pkg::NORM_LAST;
		sts.div_need  = (bias_q != 32'sd0) && (prod_q[63:32] < babs);
		sts.div_last  = dcnt_q == tpls_pkg::DIV_LAST;
		sts.out_free  = !m_tvalid || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q <= '0;
			exp_q   <= tpls_pkg::EXP_SQUARE;
			cnt_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tpls_pkg::CFG_NOISE: noise_q <= cfg_wdata;
				tpls_pkg::CFG_EXP:   exp_q   <= cfg_wdata[15:0];
				tpls_pkg::CFG_COUNT: cnt_q   <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture && mode == tpls_pkg::MODE_LOAD && 32'(entry_index) < MAX_BARRIERS)
			mem[IDX_W'(entry_index)] <= {entry_height, entry_amplitude};
		if (cmd.rd)
			rd_q <= mem[j_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			bias_q <= bias;
			meas_q <= measured_current;
			last_q <= last_sample;
		end
		if (cmd.chk) begin
			d_q     <= diff[31:0];
			x_q     <= diff[31:0];
			m_q     <= 5'd31;
			nstep_q <= '0;
		end
		if (cmd.norm_step) begin
			if (sh_ok) begin
				x_q <= x_q << sh;
				m_q <= m_q - sh;
			end
			nstep_q <= nstep_q + 3'd1;
		end
		if (cmd.log_mul)
			e_q <= lg * $signed({1'b0, exp_q});
		if (cmd.exp_calc)
			p_q <= p_gen;
		if (cmd.mul_sq)
			prod_q <= d_q * d_q;
		if (cmd.sq_pow)
			p_q <= (|prod_q[63:32+FRAC_BITS]) ? 32'hFFFF_FFFF : prod_q[31+FRAC_BITS:FRAC_BITS];
		if (cmd.mul_mag)
			prod_q <= aabs * p_q;
		if (cmd.dchk) begin
			bz_q   <= bias_q == 32'sd0;
			big_q  <= prod_q[63:32] >= babs;
			rem_q  <= prod_q[63:32];
			quo_q  <= prod_q[31:0];
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= ge ? 32'(rem2 - {1'b0, babs}) : rem2[31:0];
			quo_q  <= {quo_q[30:0], ge};
			dcnt_q <= dcnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q   <= '0;
			acc_q <= '0;
			zb_q  <= 1'b0;
			sat_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				j_q   <= '0;
				acc_q <= ACC_W'(noise_q);
				zb_q  <= 1'b0;
				sat_q <= 1'b0;
			end
			if (cmd.next)
				j_q <= j_q + CNT_W'(1);
			if (cmd.exp_calc && p_gen_sat)
				sat_q <= 1'b1;
			if (cmd.sq_pow && |prod_q[63:32+FRAC_BITS])
				sat_q <= 1'b1;
			if (cmd.dchk && bias_q == 32'sd0) begin
				zb_q <= 1'b1;
				if (prod_q != 64'd0)
					sat_q <= 1'b1;
			end
			if (cmd.acc) begin
				acc_q <= acc_q + ACC_W'(term);
				if (over)
					sat_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (cmd.out_wr)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_wr) begin
			last_out <= last_q;
			if (mode_q == tpls_pkg::MODE_LOAD) begin
				model_current <= '0;
				residual      <= '0;
				zero_bias     <= 1'b0;
				saturated     <= 1'b0;
			end else begin
				model_current <= model_c;
				residual      <= res_c;
				zero_bias     <= zb_q;
				saturated     <= sat_q | model_sat | res_sat;
			end
		end
	end

endmodule

FILE: design/tpls_ctrl.sv
// ----------------------------------------------------------------------------
// tpls_ctrl
// Sequencer: walks the barrier table through the shared power/divide unit.
// ----------------------------------------------------------------------------
module tpls_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  tpls_pkg::sts_t sts,
	output tpls_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_NORM = 4'd3;
	localparam logic [3:0] S_LOG  = 4'd4;
	localparam logic [3:0] S_EXP  = 4'd5;
	localparam logic [3:0] S_SQ   = 4'd6;
	localparam logic [3:0] S_SQP  = 4'd7;
	localparam logic [3:0] S_MAG  = 4'd8;
	localparam logic [3:0] S_DCHK = 4'd9;
	localparam logic [3:0] S_DIV  = 4'd10;
	localparam logic [3:0] S_ACC  = 4'd11;
	localparam logic [3:0] S_FIN  = 4'd12;

	logic [3:0] state_q, state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					if (sts.mode == tpls_pkg::MODE_EVAL) begin
						cmd.start = 1'b1;
						state_d   = S_RD;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_RD: begin
				if (sts.done) begin
					state_d = S_FIN;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				if (!sts.active) begin
					cmd.next = 1'b1;
					state_d  = S_RD;
				end else if (sts.square) begin
					state_d = S_SQ;
				end else begin
					state_d = S_NORM;
				end
			end
			S_NORM: begin
				cmd.norm_step = 1'b1;
				if (sts.norm_last)
					state_d = S_LOG;
			end
			S_LOG: begin
				cmd.log_mul = 1'b1;
				state_d     = S_EXP;
			end
			S_EXP: begin
				cmd.exp_calc = 1'b1;
				state_d      = S_MAG;
			end
			S_SQ: begin
				cmd.mul_sq = 1'b1;
				state_d    = S_SQP;
			end
			S_SQP: begin
				cmd.sq_pow = 1'b1;
				state_d    = S_MAG;
			end
			S_MAG: begin
				cmd.mul_mag = 1'b1;
				state_d     = S_DCHK;
			end
			S_DCHK: begin
				cmd.dchk = 1'b1;
				state_d  = sts.div_need ? S_DIV : S_ACC;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc  = 1'b1;
				cmd.next = 1'b1;
				state_d  = S_RD;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_wr = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

FILE: design/threshold_power_law_sum.sv
// ----------------------------------------------------------------------------
// threshold_power_law_sum
// Multi-barrier threshold power-law current model with residual.
// ----------------------------------------------------------------------------
// A load transfer (tuser 0) writes one barrier entry and returns a zero
// result. An evaluate transfer (tuser 1) walks every entry in use: an entry
// is skipped when the bias is at or above the barrier; otherwise its power is
// formed by squaring (exponent two) or by normalize, log and exp steps (other
// exponents), and the bit-serial divider runs when the bias is non-zero and
// the quotient fits in 32 bits. One item is worked at a time through the
// multiply steps and a single divider; the result register lets the next item
// in while the previous result waits.
module threshold_power_law_sum #(
	parameter int MAX_BARRIERS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// entry_index, entry_height, entry_amplitude, bias, measured_current, pad
	input  logic [135:0] s_tdata,
	// mode
	input  logic         s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// model_current, residual
	output logic [63:0]  m_tdata,
	// zero_bias, saturated
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	tpls_pkg::cmd_t cmd;
	tpls_pkg::sts_t sts;

	tpls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tpls_dp #(
		.MAX_BARRIERS (MAX_BARRIERS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.mode             (s_tuser),
		.entry_index      (s_tdata[3:0]),
		.entry_height     (s_tdata[35:4]),
		.entry_amplitude  (s_tdata[67:36]),
		.bias             (s_tdata[99:68]),
		.measured_current (s_tdata[131:100]),
		.last_sample      (s_tlast),
		.m_tready         (m_tready),
		.m_tvalid         (m_tvalid),
		.model_current    (m_tdata[31:0]),
		.residual         (m_tdata[63:32]),
		.zero_bias        (m_tuser[0]),
		.saturated        (m_tuser[1]),
		.last_out         (m_tlast)
	);

endmodule

FILE: design/tpls_chk.sv
// ----------------------------------------------------------------------------
// tpls_chk
// Port-level checks for threshold_power_law_sum.
// ----------------------------------------------------------------------------
module tpls_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata,
	input logic [1:0]   m_tuser,
	input logic         m_tlast
);

	a_rst_no_valid: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while previous item in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("stalled result changed");

	a_no_out_while_idle_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared one cycle after input transfer");

endmodule

bind threshold_power_law_sum tpls_chk u_tpls_chk (.*);
